// ===== rtl/core/itpr_pkg.sv =====
// Shared constants and codes for the idle timeout packet receiver.
`default_nettype none
package itpr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam int DATA_W       = 8;
    localparam int TICK_W       = 16;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [TICK_W-1:0] IDLE_TICKS_RESET = 16'd1000;

    // Register index carried in the word address bit of paddr.
    localparam logic REG_IDLE_TICKS = 1'b0;

    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/itpr_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module itpr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/itpr_cfg.sv =====
// APB-style configuration register block holding the idle tick count.
`default_nettype none
module itpr_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [itpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [itpr_pkg::APB_DATA_W-1:0]    pwdata,
    output      logic [itpr_pkg::APB_DATA_W-1:0]    prdata,
    output      logic                               pready,
    output      logic [itpr_pkg::TICK_W-1:0]        o_idle_ticks
);

    logic [itpr_pkg::TICK_W-1:0] r_idle_ticks;
    logic                        hit;

    // Only one register exists; the word address selects it.
    assign hit    = (paddr[itpr_pkg::APB_ADDR_W-1] == itpr_pkg::REG_IDLE_TICKS);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks <= itpr_pkg::IDLE_TICKS_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_idle_ticks <= pwdata[itpr_pkg::TICK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = {{(itpr_pkg::APB_DATA_W - itpr_pkg::TICK_W){1'b0}}, r_idle_ticks};
        end
    end

    assign o_idle_ticks = r_idle_ticks;

endmodule
`default_nettype wire

// ===== rtl/core/idle_timeout_packet_receiver.sv =====
// Top level of the idle timeout packet receiver: control sequencer around the packet RAM.
// Byte, tick and unused-code words never raise busy, and the next word can start in the
// following cycle. A read of a ready packet of N bytes keeps busy high while the sequencer
// walks the RAM, one RAM read per cycle; each byte reaches the result ports through the RAM
// output register, with its strobe registered alongside. A read with no packet ready
// puts one status result on the ports in the cycle right after the accepting edge. The
// receiver cannot stall results. Synchronous active-low reset clears all control state;
// idle_ticks returns to 1000 and the packet RAM is left as it is.
`default_nettype none
module idle_timeout_packet_receiver (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Command side.
    input  wire logic                               start,
    output      logic                               busy,
    input  wire logic [1:0]                         i_action,
    input  wire logic [itpr_pkg::DATA_W-1:0]        i_rx_byte,
    // Result side.
    output      logic                               o_strobe,
    output      logic [itpr_pkg::DATA_W-1:0]        o_data_byte,
    output      logic                               o_last_byte,
    output      logic                               o_read_status,
    output      logic                               o_truncated,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [itpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [itpr_pkg::APB_DATA_W-1:0]    pwdata,
    output      logic [itpr_pkg::APB_DATA_W-1:0]    prdata,
    output      logic                               pready
);

    // Two-state sequencer: idle takes every word, read walks the RAM.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Packet framing state.
    logic [itpr_pkg::CNT_W-1:0]  r_wr_idx,   n_wr_idx;
    logic [itpr_pkg::CNT_W-1:0]  r_len,      n_len;
    logic                        r_ready,    n_ready;
    logic                        r_running,  n_running;
    logic [itpr_pkg::TICK_W-1:0] r_idle_cnt, n_idle_cnt;
    logic                        r_overflow, n_overflow;
    logic [itpr_pkg::ADDR_W-1:0] r_rd_idx,   n_rd_idx;

    // Result register; the data byte itself comes straight from the RAM output register.
    logic r_valid,  n_valid;
    logic r_last,   n_last;
    logic r_status, n_status;
    logic r_trunc,  n_trunc;

    logic                          accept;
    logic [itpr_pkg::TICK_W-1:0]   cnt_inc;
    logic [itpr_pkg::TICK_W-1:0]   idle_ticks;
    logic                          ram_we;
    logic                          ram_re;
    logic [itpr_pkg::DATA_W-1:0]   ram_q;
    logic                          rd_is_last;

    itpr_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_idle_ticks (idle_ticks)
    );

    itpr_ram #(
        .DATA_W (itpr_pkg::DATA_W),
        .DEPTH  (itpr_pkg::BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx[itpr_pkg::ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_q)
    );

    // Busy only while a packet is being streamed out of the RAM.
    assign busy   = (r_state == S_READ);
    assign accept = start && !busy;

    // The idle counter saturates at its maximum rather than wrapping.
    assign cnt_inc = (r_idle_cnt == {itpr_pkg::TICK_W{1'b1}}) ?
                     r_idle_cnt : r_idle_cnt + itpr_pkg::TICK_W'(1);

    assign rd_is_last = ({1'b0, r_rd_idx} + itpr_pkg::CNT_W'(1)) == r_len;

    always_comb begin
        n_state    = r_state;
        n_wr_idx   = r_wr_idx;
        n_len      = r_len;
        n_ready    = r_ready;
        n_running  = r_running;
        n_idle_cnt = r_idle_cnt;
        n_overflow = r_overflow;
        n_rd_idx   = r_rd_idx;
        n_valid    = 1'b0;
        n_last     = 1'b0;
        n_status   = 1'b0;
        n_trunc    = r_trunc;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        itpr_pkg::ACT_BYTE: begin
                            // Bytes are ignored outright while a finished packet waits.
                            if (!r_ready) begin
                                n_idle_cnt = '0;
                                n_running  = 1'b1;
                                if (r_wr_idx < itpr_pkg::CNT_W'(itpr_pkg::BUFFER_DEPTH)) begin
                                    ram_we   = 1'b1;
                                    n_wr_idx = r_wr_idx + itpr_pkg::CNT_W'(1);
                                end else begin
                                    n_overflow = 1'b1;
                                end
                            end
                        end
                        itpr_pkg::ACT_TICK: begin
                            if (r_running) begin
                                n_idle_cnt = cnt_inc;
                                // A zero setting closes on the first tick, like a one.
                                if (cnt_inc >= idle_ticks) begin
                                    n_ready    = 1'b1;
                                    n_len      = r_wr_idx;
                                    n_wr_idx   = '0;
                                    n_running  = 1'b0;
                                    n_idle_cnt = '0;
                                end
                            end
                        end
                        itpr_pkg::ACT_READ: begin
                            if (r_ready && (r_len != '0)) begin
                                n_state  = S_READ;
                                n_rd_idx = '0;
                                n_trunc  = r_overflow;
                            end else begin
                                n_valid  = 1'b1;
                                n_last   = 1'b1;
                                n_status = 1'b1;
                                n_trunc  = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // One RAM read per cycle; the result shows when the read data lands.
                ram_re   = 1'b1;
                n_valid  = 1'b1;
                n_last   = rd_is_last;
                n_rd_idx = r_rd_idx + itpr_pkg::ADDR_W'(1);
                if (rd_is_last) begin
                    n_state    = S_IDLE;
                    n_ready    = 1'b0;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wr_idx   <= '0;
            r_len      <= '0;
            r_ready    <= 1'b0;
            r_running  <= 1'b0;
            r_idle_cnt <= '0;
            r_overflow <= 1'b0;
            r_rd_idx   <= '0;
            r_valid    <= 1'b0;
            r_last     <= 1'b0;
            r_status   <= 1'b0;
            r_trunc    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_idx   <= n_wr_idx;
            r_len      <= n_len;
            r_ready    <= n_ready;
            r_running  <= n_running;
            r_idle_cnt <= n_idle_cnt;
            r_overflow <= n_overflow;
            r_rd_idx   <= n_rd_idx;
            r_valid    <= n_valid;
            r_last     <= n_last;
            r_status   <= n_status;
            r_trunc    <= n_trunc;
        end
    end

    // A "none" status carries a zero data byte and no truncation flag.
    assign o_strobe      = r_valid;
    assign o_data_byte   = r_status ? '0 : ram_q;
    assign o_last_byte   = r_last;
    assign o_read_status = r_status;
    assign o_truncated   = r_trunc;

endmodule
`default_nettype wire
